// ----- src/owbg_pkg.sv -----
// ----------------------------------------------------------------------------
// owbg_pkg: shared types and constants
// Status codes, stage records and fixed widths of the white-balance gain block.
// ----------------------------------------------------------------------------
package owbg_pkg;

    localparam int AVG_W   = 8;
    localparam int RATIO_W = 16;
    localparam int GAIN_W  = 16;
    localparam int SCALE_SHIFT = 9;   // ratios are scaled by 512

    localparam logic [AVG_W-1:0]   VALID_MARK  = 8'h01;
    localparam logic [AVG_W-1:0]   SUM_MOD     = 8'hFF;
    localparam logic [GAIN_W-1:0]  UNITY_GAIN  = 16'h0100;
    localparam logic [RATIO_W-1:0] GOLD_RED_RESET  = 16'd298;
    localparam logic [RATIO_W-1:0] GOLD_BLUE_RESET = 16'd356;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FLAG     = 2'd1,
        STAT_CHECKSUM = 2'd2,
        STAT_ZERO     = 2'd3
    } status_t;

    typedef enum logic {
        REG_GOLD_RED  = 1'b0,
        REG_GOLD_BLUE = 1'b1
    } reg_index_t;

    typedef struct packed {
        status_t          status;
        logic [AVG_W-1:0] red;
        logic [AVG_W-1:0] green_red;
        logic [AVG_W-1:0] green_blue;
        logic [AVG_W-1:0] blue;
    } front_t;

    typedef struct packed {
        status_t            status;
        logic [RATIO_W-1:0] red_ratio;
        logic [RATIO_W-1:0] blue_ratio;
    } ratio_t;

endpackage

// ----- src/owbg_check.sv -----
// ----------------------------------------------------------------------------
// owbg_check: record check stage
// Checks flag, mod-255 checksum and zero greens; registers the four averages.
// ----------------------------------------------------------------------------
module owbg_check
    import owbg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [AVG_W-1:0] valid_flag,
    input  logic [AVG_W-1:0] red_average,
    input  logic [AVG_W-1:0] green_red_average,
    input  logic [AVG_W-1:0] green_blue_average,
    input  logic [AVG_W-1:0] blue_average,
    input  logic [AVG_W-1:0] extra_byte_a,
    input  logic [AVG_W-1:0] extra_byte_b,
    input  logic [AVG_W-1:0] extra_byte_c,
    input  logic [AVG_W-1:0] extra_byte_d,
    input  logic [AVG_W-1:0] extra_byte_e,
    input  logic [AVG_W-1:0] extra_byte_f,
    input  logic [AVG_W-1:0] stored_checksum,
    output logic             out_valid,
    output front_t           front
);

    logic             valid_reg;
    front_t           front_reg;
    front_t           front_next;
    logic [11:0]      sum;
    logic [8:0]       fold;
    logic [AVG_W-1:0] fold2;
    logic [AVG_W-1:0] sum_mod;

    always_comb
    begin
        sum = 12'(red_average) + 12'(green_red_average) + 12'(green_blue_average)
            + 12'(blue_average) + 12'(extra_byte_a) + 12'(extra_byte_b)
            + 12'(extra_byte_c) + 12'(extra_byte_d) + 12'(extra_byte_e)
            + 12'(extra_byte_f);
        // 256 is 1 mod 255: fold the high bits back in twice
        fold    = 9'(sum[11:8]) + 9'(sum[7:0]);
        fold2   = fold[7:0] + 8'(fold[8]);
        sum_mod = (fold2 == SUM_MOD) ? '0 : fold2;

        front_next.red        = red_average;
        front_next.green_red  = green_red_average;
        front_next.green_blue = green_blue_average;
        front_next.blue       = blue_average;
        if (valid_flag != VALID_MARK)
            front_next.status = STAT_FLAG;
        else if (sum_mod != stored_checksum)
            front_next.status = STAT_CHECKSUM;
        else if (green_red_average == '0 || green_blue_average == '0)
            front_next.status = STAT_ZERO;
        else
            front_next.status = STAT_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg <= front_next;
        end
    end

    assign out_valid = valid_reg;
    assign front     = front_reg;

endmodule

// ----- src/owbg_div.sv -----
// ----------------------------------------------------------------------------
// owbg_div: pipelined restoring divider
// One quotient bit per stage for several lanes, with a sideband carried along.
// ----------------------------------------------------------------------------
module owbg_div #(
    parameter int LANES = 2,
    parameter int NW    = 17,
    parameter int DW    = 8,
    parameter int SW    = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NW-1:0]    num,
    input  logic [LANES-1:0][DW-1:0]    den,
    input  logic [SW-1:0]               side,
    output logic                        out_valid,
    output logic [LANES-1:0][NW-1:0]    quo,
    output logic [SW-1:0]               side_out
);

    // nq holds the numerator bits still to use, quotient bits shift in below
    logic                       valid_reg [NW];
    logic [LANES-1:0][DW-1:0]   rem_reg   [NW];
    logic [LANES-1:0][NW-1:0]   nq_reg    [NW];
    logic [LANES-1:0][DW-1:0]   den_reg   [NW];
    logic [SW-1:0]              side_reg  [NW];

    logic                       valid_in  [NW];
    logic [LANES-1:0][DW-1:0]   rem_in    [NW];
    logic [LANES-1:0][NW-1:0]   nq_in     [NW];
    logic [LANES-1:0][DW-1:0]   den_in    [NW];
    logic [SW-1:0]              side_in   [NW];
    logic [LANES-1:0][DW-1:0]   rem_next  [NW];
    logic [LANES-1:0][NW-1:0]   nq_next   [NW];

    always_comb
    begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        valid_in[0] = in_valid;
        rem_in[0]   = '0;
        nq_in[0]    = num;
        den_in[0]   = den;
        side_in[0]  = side;
        for (int k = 1; k < NW; k++)
        begin
            valid_in[k] = valid_reg[k-1];
            rem_in[k]   = rem_reg[k-1];
            nq_in[k]    = nq_reg[k-1];
            den_in[k]   = den_reg[k-1];
            side_in[k]  = side_reg[k-1];
        end
        for (int k = 0; k < NW; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_in[k][l], nq_in[k][l][NW-1]};
                diff  = trial - {1'b0, den_in[k][l]};
                if (trial >= {1'b0, den_in[k][l]})
                begin
                    rem_next[k][l] = diff[DW-1:0];
                    nq_next[k][l]  = {nq_in[k][l][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = trial[DW-1:0];
                    nq_next[k][l]  = {nq_in[k][l][NW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NW; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < NW; k++)
                valid_reg[k] <= valid_in[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                nq_reg[k]   <= nq_next[k];
                den_reg[k]  <= den_in[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign quo       = nq_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

// ----- src/owbg_select.sv -----
// ----------------------------------------------------------------------------
// owbg_select: gain selection and output register
// Picks the channel held at unity and registers the three gains and status.
// ----------------------------------------------------------------------------
module owbg_select
    import owbg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  ratio_t            ratio,
    input  logic [GAIN_W-1:0] green_red_q,   // unity*512 / red ratio
    input  logic [GAIN_W-1:0] green_blue_q,  // unity*512 / blue ratio
    input  logic [GAIN_W-1:0] blue_red_q,    // unity*blue / red ratio
    input  logic [GAIN_W-1:0] red_blue_q,    // unity*red / blue ratio
    output logic              out_valid,
    output logic [1:0]        status,
    output logic [GAIN_W-1:0] red_gain,
    output logic [GAIN_W-1:0] green_gain,
    output logic [GAIN_W-1:0] blue_gain
);

    logic              valid_reg;
    status_t           status_reg;
    logic [GAIN_W-1:0] red_reg, red_next;
    logic [GAIN_W-1:0] green_reg, green_next;
    logic [GAIN_W-1:0] blue_reg, blue_next;
    logic              red_big;
    logic              blue_big;
    logic              red_unity;

    always_comb
    begin
        red_big  = ratio.red_ratio[RATIO_W-1:SCALE_SHIFT] != '0;
        blue_big = ratio.blue_ratio[RATIO_W-1:SCALE_SHIFT] != '0;
        priority if (red_big)
            red_unity = 1'b0;
        else if (blue_big)
            red_unity = 1'b1;
        else
            red_unity = green_red_q >= green_blue_q;

        if (ratio.status != STAT_OK)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
        else if (red_big && blue_big)
        begin
            // unity * ratio / 512 is a right shift by one
            red_next   = {1'b0, ratio.red_ratio[RATIO_W-1:1]};
            green_next = UNITY_GAIN;
            blue_next  = {1'b0, ratio.blue_ratio[RATIO_W-1:1]};
        end
        else if (red_unity)
        begin
            red_next   = UNITY_GAIN;
            green_next = green_red_q;
            blue_next  = blue_red_q;
        end
        else
        begin
            red_next   = red_blue_q;
            green_next = green_blue_q;
            blue_next  = UNITY_GAIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= ratio.status;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
        end
    end

    assign out_valid  = valid_reg;
    assign status     = status_reg;
    assign red_gain   = red_reg;
    assign green_gain = green_reg;
    assign blue_gain  = blue_reg;

endmodule

// ----- src/otp_white_balance_gain_calc_top.sv -----
// ----------------------------------------------------------------------------
// otp_white_balance_gain_calc_top: white-balance gains from a calibration record
// Checks the record, forms unit and golden ratios and picks the RGB gains.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_ready     valid_flag .. stored_checksum
//  out      out_valid / out_ready   status, red_gain, green_gain, blue_gain
//  config   wr_en                   wr_index, wr_data
//
//  One record per cycle while no result is held; check stage, 17-stage unit ratio
//  divider, 25-stage golden ratio divider, 24-stage gain divider, output register.
//  The divider chain sets the depth; every stage is one quotient bit.
//  Reset clears all valid bits and loads the golden ratio defaults.
//  A held result stalls the whole pipeline; in_ready follows that stall.
// ----------------------------------------------------------------------------
module otp_white_balance_gain_calc_top
    import owbg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [RATIO_W-1:0] wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [AVG_W-1:0]   valid_flag,
    input  logic [AVG_W-1:0]   red_average,
    input  logic [AVG_W-1:0]   green_red_average,
    input  logic [AVG_W-1:0]   green_blue_average,
    input  logic [AVG_W-1:0]   blue_average,
    input  logic [AVG_W-1:0]   extra_byte_a,
    input  logic [AVG_W-1:0]   extra_byte_b,
    input  logic [AVG_W-1:0]   extra_byte_c,
    input  logic [AVG_W-1:0]   extra_byte_d,
    input  logic [AVG_W-1:0]   extra_byte_e,
    input  logic [AVG_W-1:0]   extra_byte_f,
    input  logic [AVG_W-1:0]   stored_checksum,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [GAIN_W-1:0]  red_gain,
    output logic [GAIN_W-1:0]  green_gain,
    output logic [GAIN_W-1:0]  blue_gain
);

    localparam int UNIT_NW = AVG_W + SCALE_SHIFT;
    localparam int GOLD_NW = RATIO_W + SCALE_SHIFT;
    localparam int GAIN_NW = 24;

    logic [RATIO_W-1:0] gold_red_reg;
    logic [RATIO_W-1:0] gold_blue_reg;
    logic               en;

    logic               front_valid;
    front_t             front;

    logic [1:0][UNIT_NW-1:0] unit_num;
    logic [1:0][AVG_W-1:0]   unit_den;
    logic [1:0][UNIT_NW-1:0] unit_quo;
    logic [1:0]              unit_side;
    logic                    unit_valid;
    logic [RATIO_W-1:0]      rg, bg;
    status_t                 unit_status;

    logic [1:0][GOLD_NW-1:0] gold_num;
    logic [1:0][RATIO_W-1:0] gold_den;
    logic [1:0][GOLD_NW-1:0] gold_quo;
    logic [1:0]              gold_side;
    logic                    gold_valid;
    ratio_t                  ratio_in;

    logic [3:0][GAIN_NW-1:0] gain_num;
    logic [3:0][RATIO_W-1:0] gain_den;
    logic [3:0][GAIN_NW-1:0] gain_quo;
    logic [$bits(ratio_t)-1:0] gain_side;
    logic                    gain_valid;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gold_red_reg  <= GOLD_RED_RESET;
            gold_blue_reg <= GOLD_BLUE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_GOLD_RED:  gold_red_reg  <= wr_data;
                REG_GOLD_BLUE: gold_blue_reg <= wr_data;
                default: ;
            endcase
        end
    end

    owbg_check u_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en),
        .in_valid           (in_valid),
        .valid_flag         (valid_flag),
        .red_average        (red_average),
        .green_red_average  (green_red_average),
        .green_blue_average (green_blue_average),
        .blue_average       (blue_average),
        .extra_byte_a       (extra_byte_a),
        .extra_byte_b       (extra_byte_b),
        .extra_byte_c       (extra_byte_c),
        .extra_byte_d       (extra_byte_d),
        .extra_byte_e       (extra_byte_e),
        .extra_byte_f       (extra_byte_f),
        .stored_checksum    (stored_checksum),
        .out_valid          (front_valid),
        .front              (front)
    );

    // unit ratios: 512*R/Gr and 512*B/Gb
    assign unit_num[0] = {front.red, SCALE_SHIFT'(0)};
    assign unit_num[1] = {front.blue, SCALE_SHIFT'(0)};
    assign unit_den[0] = front.green_red;
    assign unit_den[1] = front.green_blue;

    owbg_div #(
        .LANES (2),
        .NW    (UNIT_NW),
        .DW    (AVG_W),
        .SW    (2)
    ) u_div_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .num       (unit_num),
        .den       (unit_den),
        .side      (front.status),
        .out_valid (unit_valid),
        .quo       (unit_quo),
        .side_out  (unit_side)
    );

    always_comb
    begin
        rg = unit_quo[0][RATIO_W-1:0];
        bg = unit_quo[1][RATIO_W-1:0];
        if (status_t'(unit_side) == STAT_OK && (rg == '0 || bg == '0))
            unit_status = STAT_ZERO;
        else
            unit_status = status_t'(unit_side);
    end

    // golden-based ratios: 512*golden/unit
    assign gold_num[0] = {gold_red_reg, SCALE_SHIFT'(0)};
    assign gold_num[1] = {gold_blue_reg, SCALE_SHIFT'(0)};
    assign gold_den[0] = rg;
    assign gold_den[1] = bg;

    owbg_div #(
        .LANES (2),
        .NW    (GOLD_NW),
        .DW    (RATIO_W),
        .SW    (2)
    ) u_div_gold (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (unit_valid),
        .num       (gold_num),
        .den       (gold_den),
        .side      (unit_status),
        .out_valid (gold_valid),
        .quo       (gold_quo),
        .side_out  (gold_side)
    );

    always_comb
    begin
        ratio_in.red_ratio  = gold_quo[0][RATIO_W-1:0];
        ratio_in.blue_ratio = gold_quo[1][RATIO_W-1:0];
        if (status_t'(gold_side) == STAT_OK
            && (ratio_in.red_ratio == '0 || ratio_in.blue_ratio == '0))
            ratio_in.status = STAT_ZERO;
        else
            ratio_in.status = status_t'(gold_side);
    end

    // all four gain candidates; selection happens at the output stage
    assign gain_num[0] = GAIN_NW'({UNITY_GAIN, SCALE_SHIFT'(0)});
    assign gain_num[1] = GAIN_NW'({UNITY_GAIN, SCALE_SHIFT'(0)});
    assign gain_num[2] = {ratio_in.blue_ratio, 8'h00};
    assign gain_num[3] = {ratio_in.red_ratio, 8'h00};
    assign gain_den[0] = ratio_in.red_ratio;
    assign gain_den[1] = ratio_in.blue_ratio;
    assign gain_den[2] = ratio_in.red_ratio;
    assign gain_den[3] = ratio_in.blue_ratio;

    owbg_div #(
        .LANES (4),
        .NW    (GAIN_NW),
        .DW    (RATIO_W),
        .SW    ($bits(ratio_t))
    ) u_div_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (gold_valid),
        .num       (gain_num),
        .den       (gain_den),
        .side      (ratio_in),
        .out_valid (gain_valid),
        .quo       (gain_quo),
        .side_out  (gain_side)
    );

    owbg_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (gain_valid),
        .ratio        (ratio_t'(gain_side)),
        .green_red_q  (gain_quo[0][GAIN_W-1:0]),
        .green_blue_q (gain_quo[1][GAIN_W-1:0]),
        .blue_red_q   (gain_quo[2][GAIN_W-1:0]),
        .red_blue_q   (gain_quo[3][GAIN_W-1:0]),
        .out_valid    (out_valid),
        .status       (status),
        .red_gain     (red_gain),
        .green_gain   (green_gain),
        .blue_gain    (blue_gain)
    );

endmodule
